// ----- design/pfc_pkg.sv -----
package pfc_pkg;

   localparam int LetterW  = 5;
   localparam int SquareN  = 5;
   localparam int PosW     = 3;
   localparam int RowW     = SquareN * LetterW;
   localparam int CsrIndexW = 3;
   localparam int QueueDepth = 2;

   typedef logic [LetterW-1:0] letter_type;
   typedef logic [PosW-1:0] pos_type;
   typedef logic [SquareN-1:0][SquareN-1:0][LetterW-1:0] square_type;
   typedef logic [CsrIndexW-1:0] csr_index_type;

   localparam letter_type LETTER_X = letter_type'(23);

   localparam csr_index_type CSR_MODE = csr_index_type'(0);
   localparam csr_index_type CSR_ROW0 = csr_index_type'(1);
   localparam csr_index_type CSR_ROW1 = csr_index_type'(2);
   localparam csr_index_type CSR_ROW2 = csr_index_type'(3);
   localparam csr_index_type CSR_ROW3 = csr_index_type'(4);
   localparam csr_index_type CSR_ROW4 = csr_index_type'(5);

   typedef struct packed {
      logic       two_pairs;
      logic       drop;
      logic       dec;
      logic       last;
      letter_type a0;
      letter_type b0;
      letter_type a1;
      letter_type b1;
   } job_type;

endpackage

// ----- design/pfc_front.sv -----
module pfc_front import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  letter_type req_in_letter,
   input  logic       req_in_last,
   input  logic       dec,
   input  logic       q_full,
   output logic       req_full,
   output logic       q_push,
   output job_type    q_job
);

   logic       pf_valid_ff, pf_valid_in;
   letter_type pf_letter_ff, pf_letter_in;
   logic       held_valid_ff, held_valid_in;
   letter_type held_letter_ff, held_letter_in;
   logic       accept;
   logic       has_entry;
   logic       dup;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign dup      = held_valid_ff && (held_letter_ff == req_in_letter);

   always_comb begin
      has_entry    = 1'b0;
      q_job        = '0;
      q_job.dec    = dec;
      q_job.last   = req_in_last;
      pf_valid_in  = pf_valid_ff;
      pf_letter_in = pf_letter_ff;
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      if (accept) begin
         if (!dec) begin
            held_valid_in  = 1'b1;
            held_letter_in = req_in_letter;
            if (dup) begin
               has_entry = 1'b1;
               if (!pf_valid_ff) begin
                  q_job.a0    = LETTER_X;
                  q_job.b0    = req_in_letter;
                  pf_valid_in = 1'b0;
               end else begin
                  q_job.a0     = pf_letter_ff;
                  q_job.b0     = LETTER_X;
                  pf_valid_in  = 1'b1;
                  pf_letter_in = req_in_letter;
                  if (req_in_last) begin
                     q_job.two_pairs = 1'b1;
                     q_job.a1        = req_in_letter;
                     q_job.b1        = LETTER_X;
                  end
               end
            end else if (!pf_valid_ff) begin
               if (req_in_last) begin
                  has_entry = 1'b1;
                  q_job.a0  = req_in_letter;
                  q_job.b0  = LETTER_X;
               end else begin
                  pf_valid_in  = 1'b1;
                  pf_letter_in = req_in_letter;
               end
            end else begin
               has_entry   = 1'b1;
               q_job.a0    = pf_letter_ff;
               q_job.b0    = req_in_letter;
               pf_valid_in = 1'b0;
            end
         end else begin
            if (!pf_valid_ff) begin
               if (req_in_last) begin
                  has_entry  = 1'b1;
                  q_job.drop = 1'b1;
               end else begin
                  pf_valid_in  = 1'b1;
                  pf_letter_in = req_in_letter;
               end
            end else begin
               has_entry   = 1'b1;
               q_job.a0    = pf_letter_ff;
               q_job.b0    = req_in_letter;
               pf_valid_in = 1'b0;
            end
         end
         if (req_in_last) begin
            pf_valid_in    = 1'b0;
            pf_letter_in   = '0;
            held_valid_in  = 1'b0;
            held_letter_in = '0;
         end
      end
   end

   assign q_push = accept && has_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_valid_ff    <= 1'b0;
         pf_letter_ff   <= '0;
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
      end else begin
         pf_valid_ff    <= pf_valid_in;
         pf_letter_ff   <= pf_letter_in;
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
      end
   end

endmodule

// ----- design/pfc_queue.sv -----
module pfc_queue import pfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   job_type           slot_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/pfc_back.sv -----
module pfc_back import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  square_type square,
   input  logic       head_valid,
   input  job_type    head,
   output logic       head_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output letter_type rsp_out_letter,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic       rsp_not_in_square
);

   logic [1:0] idx_ff, idx_in;
   logic       hold_ff, hold_in;
   letter_type letter_ff, letter_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       flag_ff, flag_in;

   letter_type a, b, oa, ob, res_letter;
   logic       fa, fb, miss;
   pos_type    ra, ca, rb, cb;
   logic       final_res, load;

   function automatic pos_type wrap_shift(pos_type p, logic dec);
      logic [PosW:0] sum;
      sum = {1'b0, p} + (dec ? (PosW+1)'(SquareN - 1) : (PosW+1)'(1));
      if (sum >= (PosW+1)'(SquareN)) begin
         sum = sum - (PosW+1)'(SquareN);
      end
      return sum[PosW-1:0];
   endfunction

   assign a = idx_ff[1] ? head.a1 : head.a0;
   assign b = idx_ff[1] ? head.b1 : head.b0;

   always_comb begin
      fa = 1'b0;
      fb = 1'b0;
      ra = '0;
      ca = '0;
      rb = '0;
      cb = '0;
      for (int r = 0; r < SquareN; r++) begin
         for (int c = 0; c < SquareN; c++) begin
            if (square[r][c] == a) begin
               fa = 1'b1;
               ra = pos_type'(r);
               ca = pos_type'(c);
            end
            if (square[r][c] == b) begin
               fb = 1'b1;
               rb = pos_type'(r);
               cb = pos_type'(c);
            end
         end
      end
   end

   always_comb begin
      miss = !fa || !fb;
      if (miss) begin
         oa = a;
         ob = b;
      end else if (ra == rb) begin
         oa = square[ra][wrap_shift(ca, head.dec)];
         ob = square[ra][wrap_shift(cb, head.dec)];
      end else if (ca == cb) begin
         oa = square[wrap_shift(ra, head.dec)][ca];
         ob = square[wrap_shift(rb, head.dec)][ca];
      end else begin
         oa = square[ra][cb];
         ob = square[rb][ca];
      end
      res_letter = idx_ff[0] ? ob : oa;
   end

   assign final_res = head.drop || (idx_ff == (head.two_pairs ? 2'd3 : 2'd1));
   assign load      = head_valid && (!hold_ff || rsp_pop);
   assign head_pop  = load && final_res;

   always_comb begin
      idx_in    = idx_ff;
      hold_in   = hold_ff;
      letter_in = letter_ff;
      valid_in  = valid_ff;
      last_in   = last_ff;
      flag_in   = flag_ff;
      if (rsp_pop) begin
         hold_in = 1'b0;
      end
      if (load) begin
         hold_in   = 1'b1;
         idx_in    = final_res ? 2'd0 : idx_ff + 2'd1;
         letter_in = head.drop ? '0 : res_letter;
         valid_in  = !head.drop;
         last_in   = head.last && final_res;
         flag_in   = !head.drop && miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         hold_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      valid_ff  <= valid_in;
      last_ff   <= last_in;
      flag_ff   <= flag_in;
   end

   assign rsp_empty         = !hold_ff;
   assign rsp_out_letter    = letter_ff;
   assign rsp_out_valid     = valid_ff;
   assign rsp_out_last      = last_ff;
   assign rsp_not_in_square = flag_ff;

endmodule

// ----- design/playfair_digraph_cipher.sv -----
// Channel   Handshake            Payload
// req       push / full          req_in_letter, req_in_last
// rsp       empty / pop          rsp_out_letter, rsp_out_valid, rsp_out_last, rsp_not_in_square
// csr       csr_write_en         csr_index, csr_wdata
//
// An item is taken while the two-entry job queue has room, even one that only stores a letter;
// each item yields zero, one, two or four results. The back end delivers one result per cycle
// while the rsp side pops, and overlaps the front; an item gives at most two results, four for
// a closing doubled letter. The first result of an item passes the job queue and then the
// result register before it reaches the rsp ports. Synchronous reset clears all message state,
// the queue, the hold flag of the result register and the configuration registers. Either side
// may stall at any time; the queue lets the front keep accepting until it fills.
module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [LetterW-1:0]   req_in_letter,
   input  logic                 req_in_last,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [LetterW-1:0]   rsp_out_letter,
   output logic                 rsp_out_valid,
   output logic                 rsp_out_last,
   output logic                 rsp_not_in_square,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [RowW-1:0]      csr_wdata
);

   logic       mode_ff, mode_in;
   square_type square_ff, square_in;
   logic       q_full, q_empty, q_push, q_pop;
   job_type    q_job, q_head;

   always_comb begin
      mode_in   = mode_ff;
      square_in = square_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE: mode_in      = csr_wdata[0];
            CSR_ROW0: square_in[0] = csr_wdata;
            CSR_ROW1: square_in[1] = csr_wdata;
            CSR_ROW2: square_in[2] = csr_wdata;
            CSR_ROW3: square_in[3] = csr_wdata;
            CSR_ROW4: square_in[4] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         square_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         square_ff <= square_in;
      end
   end

   pfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_in_letter (req_in_letter),
      .req_in_last   (req_in_last),
      .dec           (mode_ff),
      .q_full        (q_full),
      .req_full      (req_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   pfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   pfc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .square            (square_ff),
      .head_valid        (!q_empty),
      .head              (q_head),
      .head_pop          (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_letter    (rsp_out_letter),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_last      (rsp_out_last),
      .rsp_not_in_square (rsp_not_in_square)
   );

endmodule

// ----- design/pfc_checker.sv -----
module pfc_checker import pfc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [LetterW-1:0]   rsp_out_letter,
   input logic                 rsp_out_valid,
   input logic                 rsp_out_last,
   input logic                 rsp_not_in_square
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("outputs not cleared after reset");

   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_out_valid |->
         rsp_out_last && (rsp_out_letter == '0) && !rsp_not_in_square)
      else $error("dropped-letter result malformed");

   a_flag_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_not_in_square |-> rsp_out_valid)
      else $error("flagged result marked invalid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_out_letter) && $stable(rsp_out_last))
      else $error("waiting result changed before transfer");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);
